// ===== rtl/rau_pkg.sv =====
package rau_pkg;

  localparam int unsigned OperandBitsDef = 16;
  localparam int unsigned ResNumBits     = 32;
  localparam int unsigned ResDenBits     = 31;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_GT  = 4'd4,
    OP_LT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9
  } rau_op_e;

  typedef struct packed {
    logic [3:0]                opcode;
    logic [OperandBitsDef-1:0] num_a;
    logic [OperandBitsDef-2:0] den_a;
    logic [OperandBitsDef-1:0] num_b;
    logic [OperandBitsDef-2:0] den_b;
  } rau_req_t;

  typedef struct packed {
    logic [ResNumBits-1:0] res_num;
    logic [ResDenBits-1:0] res_den;
    logic                  cmp_true;
    logic                  div_zero;
  } rau_res_t;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Sequence: every request runs four multiplies on one shared multiplier, then a prepare step;
// compares, zero results and divide by zero then go straight to the output step. Otherwise
// binary gcd steps follow, one subtract-and-shift step per cycle, then two restoring divides
// (numerator, then denominator, by the gcd) before the output step.
// Throughput: one transaction at a time; busy is high from accept until done_o rises.
// Reset: asynchronous, active low; the sequencer returns to idle, no result pending.
// The receiver cannot stall: the result is valid for the single cycle of done_o.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  rau_req_t                  req_i,
  output logic                      done_o,
  output rau_res_t                  res_o
);

  localparam int unsigned NB  = OperandBitsDef;
  localparam int unsigned PB  = 2 * NB;          // product width (signed)
  localparam int unsigned MB  = 2 * NB + 1;      // magnitude width of sum
  localparam int unsigned CB  = $clog2(MB + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [3:0]                 op_q;
  logic signed [NB-1:0]       a_q, b_q;
  logic [NB-2:0]              da_q, db_q;
  logic [1:0]                 mcnt_q;
  logic signed [PB-1:0]       lhs_q, rhs_q, dd_q, ab_q;
  logic                       neg_q;
  logic [MB-1:0]              mag_q, den_q, gx_q, gy_q, g_q;
  logic [CB-1:0]              sh_q;
  logic [MB-1:0]              rem_q, quo_q, dvd_q;
  logic [CB-1:0]              bcnt_q;
  logic [MB-1:0]              qn_q;
  rau_res_t                   res_q;
  logic                       done_q;

  // single shared multiplier
  logic signed [NB:0]   mx, my;
  logic signed [PB+1:0] mp;
  logic [NB-2:0]        da_f, db_f;

  always_comb begin
    da_f = (da_q == '0) ? {{(NB-2){1'b0}}, 1'b1} : da_q;
    db_f = (db_q == '0) ? {{(NB-2){1'b0}}, 1'b1} : db_q;
    case (mcnt_q)
      2'd0:    begin mx = (NB+1)'(a_q);  my = $signed({2'b00, db_f}); end
      2'd1:    begin mx = (NB+1)'(b_q);  my = $signed({2'b00, da_f}); end
      2'd2:    begin mx = (NB+1)'(a_q);  my = (NB+1)'(b_q); end
      default: begin mx = $signed({2'b00, da_f}); my = $signed({2'b00, db_f}); end
    endcase
  end
  assign mp = mx * my;

  logic signed [MB:0] nsel;
  logic [MB-1:0]      dsel;
  always_comb begin
    nsel = '0;
    dsel = MB'(dd_q);
    case (op_q)
      OP_ADD: nsel = (MB+1)'(lhs_q) + (MB+1)'(rhs_q);
      OP_SUB: nsel = (MB+1)'(lhs_q) - (MB+1)'(rhs_q);
      OP_MUL: nsel = (MB+1)'(ab_q);
      default: begin
        nsel = (b_q < 0) ? -(MB+1)'(lhs_q) : (MB+1)'(lhs_q);
        dsel = MB'(rhs_q < 0 ? -rhs_q : rhs_q);
      end
    endcase
  end

  logic [MB-1:0] gsub;
  assign gsub = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;

  logic [MB:0] rtry;
  assign rtry = {rem_q, dvd_q[MB-1]} - {1'b0, g_q};

  logic cmp_c;
  always_comb begin
    case (op_q)
      OP_GT:   cmp_c = lhs_q >  rhs_q;
      OP_LT:   cmp_c = lhs_q <  rhs_q;
      OP_GE:   cmp_c = lhs_q >= rhs_q;
      OP_LE:   cmp_c = lhs_q <= rhs_q;
      OP_EQ:   cmp_c = lhs_q == rhs_q;
      OP_NE:   cmp_c = lhs_q != rhs_q;
      default: cmp_c = 1'b0;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = S_MUL;
      S_MUL:  if (mcnt_q == 2'd3) state_d = S_PREP;
      S_PREP: state_d = (op_q inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) &&
                        !(op_q == OP_DIV && b_q == 0) && nsel != 0 ? S_GCD : S_OUT;
      S_GCD:  if (gx_q == gy_q) state_d = S_DIVN;
      S_DIVN: if (bcnt_q == CB'(MB)) state_d = S_DIVD;
      S_DIVD: if (bcnt_q == CB'(MB)) state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q <= req_i.opcode; a_q <= req_i.num_a; b_q <= req_i.num_b;
        da_q <= req_i.den_a;  db_q <= req_i.den_b; mcnt_q <= 2'd0;
      end
      S_MUL: begin
        case (mcnt_q)
          2'd0:    lhs_q <= PB'(mp);
          2'd1:    rhs_q <= PB'(mp);
          2'd2:    ab_q  <= PB'(mp);
          default: dd_q  <= PB'(mp);
        endcase
        mcnt_q <= mcnt_q + 2'd1;
      end
      S_PREP: begin
        neg_q <= nsel < 0;
        mag_q <= MB'(nsel < 0 ? -nsel : nsel);
        den_q <= dsel;
        gx_q  <= MB'(nsel < 0 ? -nsel : nsel);
        gy_q  <= dsel;
        sh_q  <= '0;
      end
      S_GCD: begin
        // binary gcd: strip common twos, then halve evens or subtract-and-halve odds
        if (gx_q == gy_q) begin
          g_q <= gx_q << sh_q; rem_q <= '0; dvd_q <= mag_q; bcnt_q <= '0;
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; sh_q <= sh_q + CB'(1);
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (gx_q > gy_q) begin
          gx_q <= gsub >> 1;
        end else begin
          gy_q <= gsub >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        if (rtry[MB]) rem_q <= {rem_q[MB-2:0], dvd_q[MB-1]};
        else          rem_q <= rtry[MB-1:0];
        dvd_q <= {dvd_q[MB-2:0], ~rtry[MB]};
        bcnt_q <= bcnt_q + CB'(1);
        if (bcnt_q == CB'(MB)) begin
          if (state_q == S_DIVN) begin
            qn_q <= dvd_q; rem_q <= '0; dvd_q <= den_q; bcnt_q <= '0;
          end else quo_q <= dvd_q;
        end
      end
      default: ;
    endcase
    if (state_q == S_OUT) begin
      res_q.cmp_true <= cmp_c;
      res_q.div_zero <= (op_q == OP_DIV) && (b_q == 0);
      if ((op_q inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) && !(op_q == OP_DIV && b_q == 0)
          && mag_q != 0) begin
        res_q.res_num <= ResNumBits'(neg_q ? -qn_q : qn_q);
        res_q.res_den <= ResDenBits'(quo_q);
      end else begin
        res_q.res_num <= '0;
        res_q.res_den <= ResDenBits'(1);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/rau_checker.sv =====
module rau_checker
  import rau_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input rau_res_t res_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.res_den != '0) else $error("zero denominator");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.div_zero |-> res_o.res_num == '0 && !res_o.cmp_true)
    else $error("divide-by-zero result not cleared");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
